// ===== rtl/sams_pkg.sv =====
// Shared constants, types and step functions of the sorted table search.
package sams_pkg;

	localparam int CAPACITY      = 4096;
	// BLOCK_SIZE must be a power of two
	localparam int BLOCK_SIZE    = 32;
	localparam int BLOCK_COUNT   = CAPACITY / BLOCK_SIZE;
	localparam int KEY_W         = 16;
	localparam int IDX_W         = 12;
	localparam int CFG_W         = 13;
	localparam int PROBES        = 3;
	localparam int WIDE_PREFIX   = 16;
	localparam int NARROW_PREFIX = 8;

	localparam int LANE_W = $clog2(BLOCK_SIZE);
	localparam int LCNT_W = $clog2(BLOCK_SIZE + 1);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int NCNT_W = $clog2(BLOCK_COUNT + 1);
	localparam int BIDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [LANE_W-1:0]     lane_t;
	typedef logic [LCNT_W-1:0]     lcnt_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [NCNT_W-1:0]     bcnt_t;
	typedef logic [BIDX_W-1:0]     bidx_t;
	typedef logic [BLOCK_SIZE-1:0] lanes_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PK_NONE = 2'd0,
		PK_QUAD = 2'd1,
		PK_BIN  = 2'd2
	} probe_kind_t;

	typedef struct packed {
		logic                valid;
		op_t                 op;
		bidx_t               row;
		lane_t               lane;
		logic                wr_ok;
		key_t                key;
		bcnt_t               base;
		bcnt_t               n;
		probe_kind_t         kind;
		key_t [PROBES-1:0]   probe;
	} stage_t;

	typedef struct packed {
		bcnt_t blocks;
		lcnt_t tail;
		lcnt_t prefix;
		logic  short_mode;
	} cfg_info_t;

	typedef struct packed {
		bcnt_t base;
		bcnt_t n;
	} pos_t;

	function automatic int desc_steps(input int blocks_max);
		int worst;
		int steps;
		int n;
		worst = 1;
		for (int b = 1; b <= blocks_max; b++) begin
			n = b;
			steps = 0;
			while (n > 1) begin
				if (n > 3) begin
					n = n - 3 * (n >> 2);
				end else begin
					n = n - (n >> 1);
				end
				steps = steps + 1;
			end
			if (steps > worst) begin
				worst = steps;
			end
		end
		return worst;
	endfunction

	localparam int DESC_STAGES = desc_steps(BLOCK_COUNT);

	function automatic probe_kind_t kind_of(input bcnt_t n);
		probe_kind_t k;
		if (int'(n) > 3) begin
			k = PK_QUAD;
		end else if (int'(n) > 1) begin
			k = PK_BIN;
		end else begin
			k = PK_NONE;
		end
		return k;
	endfunction

	// fold the probe results of the previous step into base and span
	function automatic pos_t step_apply(input stage_t s);
		pos_t       r;
		bcnt_t      q;
		bcnt_t      h;
		logic [1:0] steps;
		r.base = s.base;
		r.n    = s.n;
		q      = s.n >> 2;
		h      = s.n >> 1;
		steps  = 2'(s.probe[0] < s.key) + 2'(s.probe[1] < s.key) + 2'(s.probe[2] < s.key);
		unique case (s.kind)
			PK_QUAD: begin
				unique case (steps)
					2'd0: r.base = s.base;
					2'd1: r.base = s.base + q;
					2'd2: r.base = s.base + (q << 1);
					2'd3: r.base = s.base + q + (q << 1);
				endcase
				r.n = s.n - q - (q << 1);
			end
			PK_BIN: begin
				if (s.probe[0] < s.key) begin
					r.base = s.base + h;
				end
				r.n = s.n - h;
			end
			default: begin
				r.base = s.base;
				r.n    = s.n;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/sams_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sams_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sams_level.sv =====
// One descent stage over the block last keys: quaternary or binary step.
module sams_level (
	input  logic             clk,
	input  logic             arst_n,
	input  sams_pkg::stage_t st_in,
	output sams_pkg::stage_t st_out
);

	sams_pkg::pos_t                             pos;
	sams_pkg::probe_kind_t                      kind;
	sams_pkg::bcnt_t                            q;
	sams_pkg::bcnt_t                            h;
	sams_pkg::bcnt_t [sams_pkg::PROBES-1:0]     addr;
	sams_pkg::key_t  [sams_pkg::PROBES-1:0]     rd;
	logic                                       wr_en;
	logic                                       valid_s1;
	sams_pkg::stage_t                           st_nxt;
	sams_pkg::stage_t                           st_s1;

	assign pos   = sams_pkg::step_apply(st_in);
	assign kind  = sams_pkg::kind_of(pos.n);
	assign wr_en = st_in.valid && (st_in.op == sams_pkg::OP_WRITE) && st_in.wr_ok &&
		(st_in.lane == sams_pkg::lane_t'(sams_pkg::BLOCK_SIZE - 1));

	always_comb begin
		q = pos.n >> 2;
		h = pos.n >> 1;
		unique case (kind)
			sams_pkg::PK_QUAD: begin
				addr[0] = pos.base + q;
				addr[1] = pos.base + (q << 1);
				addr[2] = pos.base + q + (q << 1);
			end
			sams_pkg::PK_BIN: begin
				addr[0] = pos.base + h;
				addr[1] = pos.base;
				addr[2] = pos.base;
			end
			default: begin
				addr[0] = pos.base;
				addr[1] = pos.base;
				addr[2] = pos.base;
			end
		endcase
	end

	for (genvar p = 0; p < sams_pkg::PROBES; p++) begin : g_copy
		sams_ram #(
			.WIDTH(sams_pkg::KEY_W),
			.DEPTH(sams_pkg::BLOCK_COUNT)
		) u_ram (
			.clk  (clk),
			.we   (wr_en),
			.waddr(st_in.row),
			.wdata(st_in.key),
			.raddr(addr[p][sams_pkg::BIDX_W-1:0]),
			.rdata(rd[p])
		);
	end

	always_comb begin
		st_nxt      = st_in;
		st_nxt.base = pos.base;
		st_nxt.n    = pos.n;
		st_nxt.kind = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= st_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		st_s1 <= st_nxt;
	end

	always_comb begin
		st_out       = st_s1;
		st_out.valid = valid_s1;
		st_out.probe = rd;
	end

endmodule

// ===== rtl/sams_final.sv =====
// Closing probe: fold the last descent step and read the chosen block's last key.
module sams_final (
	input  logic             clk,
	input  logic             arst_n,
	input  sams_pkg::stage_t st_in,
	output sams_pkg::stage_t st_out
);

	sams_pkg::pos_t   pos;
	sams_pkg::key_t   rd;
	logic             wr_en;
	logic             valid_s1;
	sams_pkg::stage_t st_nxt;
	sams_pkg::stage_t st_s1;

	assign pos   = sams_pkg::step_apply(st_in);
	assign wr_en = st_in.valid && (st_in.op == sams_pkg::OP_WRITE) && st_in.wr_ok &&
		(st_in.lane == sams_pkg::lane_t'(sams_pkg::BLOCK_SIZE - 1));

	sams_ram #(
		.WIDTH(sams_pkg::KEY_W),
		.DEPTH(sams_pkg::BLOCK_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(st_in.row),
		.wdata(st_in.key),
		.raddr(pos.base[sams_pkg::BIDX_W-1:0]),
		.rdata(rd)
	);

	always_comb begin
		st_nxt      = st_in;
		st_nxt.base = pos.base;
		st_nxt.n    = pos.n;
		st_nxt.kind = sams_pkg::PK_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= st_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		st_s1 <= st_nxt;
	end

	always_comb begin
		st_out          = st_s1;
		st_out.valid    = valid_s1;
		st_out.probe    = '0;
		st_out.probe[0] = rd;
	end

endmodule

// ===== rtl/sams_match.sv =====
// Block row read, parallel lane compare and first-at-or-above resolve.
module sams_match (
	input  logic                clk,
	input  logic                arst_n,
	input  sams_pkg::stage_t    st_in,
	input  sams_pkg::cfg_info_t cfg,
	output logic                done,
	output logic                found
);

	sams_pkg::bcnt_t  lo;
	logic             full;
	sams_pkg::bidx_t  row;
	sams_pkg::lcnt_t  pre_len;
	sams_pkg::lcnt_t  end_len;
	sams_pkg::lanes_t pre_mask;
	sams_pkg::lanes_t rng_mask;
	sams_pkg::key_t   lane_rd [sams_pkg::BLOCK_SIZE];
	sams_pkg::lanes_t eq;
	sams_pkg::lanes_t ge;
	sams_pkg::lanes_t first;

	logic             valid_s1;
	sams_pkg::key_t   key_s1;
	sams_pkg::lanes_t pre_s1;
	sams_pkg::lanes_t rng_s1;

	logic             valid_s2;
	sams_pkg::lanes_t eqp_s2;
	sams_pkg::lanes_t eqr_s2;
	sams_pkg::lanes_t ger_s2;

	logic             done_s3;
	logic             found_s3;

	// pick the block row and the lane windows
	always_comb begin
		lo   = (st_in.probe[0] < st_in.key) ? st_in.base + 1'b1 : st_in.base;
		full = !cfg.short_mode && (lo < cfg.blocks);
		row  = full ? lo[sams_pkg::BIDX_W-1:0] : cfg.blocks[sams_pkg::BIDX_W-1:0];
		if (full) begin
			pre_len = sams_pkg::lcnt_t'(sams_pkg::BLOCK_SIZE);
			end_len = sams_pkg::lcnt_t'(sams_pkg::BLOCK_SIZE);
		end else if (cfg.short_mode) begin
			pre_len = cfg.prefix;
			end_len = cfg.tail;
		end else begin
			pre_len = '0;
			end_len = cfg.tail;
		end
		for (int j = 0; j < sams_pkg::BLOCK_SIZE; j++) begin
			pre_mask[j] = sams_pkg::lcnt_t'(j) < pre_len;
			rng_mask[j] = (sams_pkg::lcnt_t'(j) >= pre_len) &&
				(sams_pkg::lcnt_t'(j) < end_len);
		end
	end

	for (genvar g = 0; g < sams_pkg::BLOCK_SIZE; g++) begin : g_lane
		sams_ram #(
			.WIDTH(sams_pkg::KEY_W),
			.DEPTH(sams_pkg::BLOCK_COUNT)
		) u_ram (
			.clk  (clk),
			.we   (st_in.valid && (st_in.op == sams_pkg::OP_WRITE) && st_in.wr_ok &&
				(st_in.lane == sams_pkg::lane_t'(g))),
			.waddr(st_in.row),
			.wdata(st_in.key),
			.raddr(row),
			.rdata(lane_rd[g])
		);
	end

	always_comb begin
		for (int j = 0; j < sams_pkg::BLOCK_SIZE; j++) begin
			eq[j] = lane_rd[j] == key_s1;
			ge[j] = lane_rd[j] >= key_s1;
		end
		first = ger_s2 & (~ger_s2 + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			valid_s1 <= st_in.valid && (st_in.op == sams_pkg::OP_QUERY);
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		key_s1   <= st_in.key;
		pre_s1   <= pre_mask;
		rng_s1   <= rng_mask;
		eqp_s2   <= eq & pre_s1;
		eqr_s2   <= eq & rng_s1;
		ger_s2   <= ge & rng_s1;
		found_s3 <= (|eqp_s2) || (|(first & eqr_s2));
	end

	assign done  = done_s3;
	assign found = found_s3;

endmodule

// ===== rtl/sorted_array_membership_search.sv =====
// Sorted key table with a pipelined membership search.
// Pipeline: done and found follow an accepted query through the DESC_STAGES descent stages,
//   the closing probe and the match registers; the block descent sets the depth, one search step per stage.
// Throughput: one beat per cycle while busy is low, writes and queries alike; a write yields no result.
// Reset: count clears to 0, busy is high until the first clock after reset, table undefined
//   until written; done has no backpressure, each result lasts one cycle.
module sorted_array_membership_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [sams_pkg::IDX_W-1:0]   entry_index,
	input  logic [sams_pkg::KEY_W-1:0]   key,
	output logic                         done,
	output logic                         found,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sams_pkg::CFG_W-1:0]   element_count
);

	logic [sams_pkg::CFG_W-1:0] count_q;
	logic                       ready_q;
	sams_pkg::cnt_t             count_sat;
	sams_pkg::cfg_info_t        cfg_info;
	sams_pkg::stage_t           st0;
	sams_pkg::stage_t           lvl_st [sams_pkg::DESC_STAGES];
	sams_pkg::stage_t           fin_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				count_q <= element_count;
			end
		end
	end

	assign busy      = !ready_q;
	assign cfg_ready = ready_q;

	// clamp the count to the table size, split it into blocks and tail and pick the prefix length
	always_comb begin
		count_sat = (int'(count_q) > sams_pkg::CAPACITY) ?
			sams_pkg::cnt_t'(sams_pkg::CAPACITY) : sams_pkg::cnt_t'(count_q);
		cfg_info.blocks     = sams_pkg::bcnt_t'(count_sat >> sams_pkg::LANE_W);
		cfg_info.tail       = sams_pkg::lcnt_t'(count_sat[sams_pkg::LANE_W-1:0]);
		cfg_info.short_mode = int'(count_sat) < sams_pkg::BLOCK_SIZE;
		if (int'(cfg_info.tail) >= sams_pkg::WIDE_PREFIX) begin
			cfg_info.prefix = sams_pkg::lcnt_t'(sams_pkg::WIDE_PREFIX);
		end else if (int'(cfg_info.tail) >= sams_pkg::NARROW_PREFIX) begin
			cfg_info.prefix = sams_pkg::lcnt_t'(sams_pkg::NARROW_PREFIX);
		end else begin
			cfg_info.prefix = '0;
		end
	end

	always_comb begin
		st0       = '0;
		st0.valid = start && !busy;
		st0.op    = sams_pkg::op_t'(op);
		st0.row   = sams_pkg::bidx_t'(entry_index >> sams_pkg::LANE_W);
		st0.lane  = entry_index[sams_pkg::LANE_W-1:0];
		st0.wr_ok = int'(entry_index) < sams_pkg::CAPACITY;
		st0.key   = key;
		st0.base  = '0;
		st0.n     = cfg_info.blocks;
		st0.kind  = sams_pkg::PK_NONE;
	end

	for (genvar i = 0; i < sams_pkg::DESC_STAGES; i++) begin : g_lvl
		if (i == 0) begin : g_first
			sams_level u_lvl (
				.clk   (clk),
				.arst_n(arst_n),
				.st_in (st0),
				.st_out(lvl_st[i])
			);
		end else begin : g_next
			sams_level u_lvl (
				.clk   (clk),
				.arst_n(arst_n),
				.st_in (lvl_st[i-1]),
				.st_out(lvl_st[i])
			);
		end
	end

	sams_final u_final (
		.clk   (clk),
		.arst_n(arst_n),
		.st_in (lvl_st[sams_pkg::DESC_STAGES-1]),
		.st_out(fin_st)
	);

	sams_match u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.st_in (fin_st),
		.cfg   (cfg_info),
		.done  (done),
		.found (found)
	);

endmodule

// ===== sim/sams_checker.sv =====
`timescale 1ns / 1ps
// Watches the sorted table search ports, predicts each query answer and checks every result.
module sams_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       op,
	input  logic [sams_pkg::IDX_W-1:0] entry_index,
	input  logic [sams_pkg::KEY_W-1:0] key,
	input  logic                       done,
	input  logic                       found,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [sams_pkg::CFG_W-1:0] element_count,
	output int                         mismatch_count,
	output int                         found_owed
);
	import sams_pkg::*;

	key_t keys_mirror [CAPACITY];
	key_t block_tops [BLOCK_COUNT];
	int   live_count;
	logic found_queue [$];
	int   errs;

	function automatic logic ordered_scan(input int from, input int upto, input key_t k);
		for (int j = from; j < upto && j < CAPACITY; j++) begin
			if (keys_mirror[j] >= k) begin
				return keys_mirror[j] == k;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic lane_match(input int from, input int len, input key_t k);
		logic hit;
		hit = 1'b0;
		for (int j = from; j < from + len && j < CAPACITY; j++) begin
			hit = hit | (keys_mirror[j] == k);
		end
		return hit;
	endfunction

	function automatic logic lookup_found(input key_t k);
		int blocks;
		int base;
		int span;
		int q;
		int h;
		int steps;
		int lo;
		if (live_count < BLOCK_SIZE) begin
			if (live_count >= WIDE_PREFIX) begin
				return lane_match(0, WIDE_PREFIX, k) || ordered_scan(WIDE_PREFIX, live_count, k);
			end
			if (live_count >= NARROW_PREFIX) begin
				return lane_match(0, NARROW_PREFIX, k) ||
					ordered_scan(NARROW_PREFIX, live_count, k);
			end
			return ordered_scan(0, live_count, k);
		end
		blocks = live_count / BLOCK_SIZE;
		base   = 0;
		span   = blocks;
		while (span > 3) begin
			q     = span >> 2;
			steps = 0;
			if (block_tops[base + q] < k) begin
				steps++;
			end
			if (block_tops[base + 2 * q] < k) begin
				steps++;
			end
			if (block_tops[base + 3 * q] < k) begin
				steps++;
			end
			base = base + steps * q;
			span = span - 3 * q;
		end
		while (span > 1) begin
			h = span >> 1;
			if (block_tops[base + h] < k) begin
				base = base + h;
			end
			span = span - h;
		end
		lo = (block_tops[base] < k) ? base + 1 : base;
		if (lo < blocks) begin
			return lane_match(lo * BLOCK_SIZE, BLOCK_SIZE, k);
		end
		return ordered_scan(blocks * BLOCK_SIZE, live_count, k);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			live_count = 0;
			found_queue.delete();
			errs = 0;
			mismatch_count <= 0;
			found_owed <= 0;
		end else begin
			if (done) begin
				if (found_queue.size() == 0) begin
					errs++;
					$display("%0t unexpected result: expected none, actual found=%0b",
						$time, found);
				end else begin
					want = found_queue.pop_front();
					if (found !== want) begin
						errs++;
						$display("%0t found mismatch: expected %0b, actual %0b",
							$time, want, found);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				live_count = (element_count > CAPACITY) ? CAPACITY : int'(element_count);
			end
			if (start && !busy) begin
				if (op == OP_QUERY) begin
					found_queue.push_back(lookup_found(key));
				end else begin
					keys_mirror[entry_index] = key;
					if (entry_index % BLOCK_SIZE == BLOCK_SIZE - 1) begin
						block_tops[entry_index / BLOCK_SIZE] = key;
					end
				end
			end
			mismatch_count <= errs;
			found_owed <= found_queue.size();
		end
	end

endmodule

// ===== sim/tb_sorted_array_membership_search.sv =====
`timescale 1ns / 1ps
// Top of the sorted table search testbench: clock, reset, table loads, queries and verdict.
module tb_sorted_array_membership_search;
	import sams_pkg::*;

	localparam int DRAIN        = DESC_STAGES + 8;
	localparam int RANDOM_ITEMS = 1000;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic             busy;
	logic             op          = 1'b0;
	logic [IDX_W-1:0] entry_index = '0;
	key_t             key         = '0;
	logic             done;
	logic             found;
	logic             cfg_valid   = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_count   = '0;

	int   mismatch_count;
	int   found_owed;
	int   idle_pct = 0;
	int   beats = 0;
	int   sorted_len = 0;
	int   idle_plan [4] = '{0, 72, 0, 32};
	key_t shadow [CAPACITY];

	sorted_array_membership_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.entry_index   (entry_index),
		.key           (key),
		.done          (done),
		.found         (found),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.element_count (cfg_count)
	);

	sams_checker search_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.entry_index    (entry_index),
		.key            (key),
		.done           (done),
		.found          (found),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.element_count  (cfg_count),
		.mismatch_count (mismatch_count),
		.found_owed     (found_owed)
	);

	always #1 clk = ~clk;

	initial begin
		#800000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_beat(input op_t o, input int idx, input key_t k);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		entry_index <= idx[IDX_W-1:0];
		key <= k;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (o == OP_WRITE) begin
			shadow[idx] = k;
		end
		beats++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (found_owed != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_count(input int value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_count <= value[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// keep entries non-decreasing from 'from' up to 'upto' - 1
	task automatic load_sorted(input int from, input int upto);
		int lo;
		int gap;
		int v;
		if (upto <= from) begin
			return;
		end
		lo  = (from == 0) ? 0 : int'(shadow[from - 1]);
		gap = (2 * (65535 - lo)) / (upto - from);
		if ($urandom_range(3) == 0) begin
			gap = 2;
		end
		for (int j = from; j < upto; j++) begin
			v  = lo + $urandom_range(gap);
			v  = (v > 65535) ? 65535 : v;
			send_beat(OP_WRITE, j, key_t'(v));
			lo = v;
		end
		sorted_len = upto;
	endtask

	task automatic load_unsorted(input int upto);
		for (int j = 0; j < upto; j++) begin
			send_beat(OP_WRITE, j, key_t'($urandom_range(65535)));
		end
		sorted_len = 0;
	endtask

	function automatic key_t pick_query_key(input int n);
		int   r;
		key_t k;
		r = $urandom_range(99);
		if (n > 0 && r < 50) begin
			k = shadow[$urandom_range(n - 1)];
		end else if (n > 0 && r < 70) begin
			k = shadow[$urandom_range(n - 1)] + (r[0] ? 16'h0001 : 16'hFFFF);
		end else if (r < 80) begin
			k = r[0] ? '1 : '0;
		end else begin
			k = key_t'($urandom_range(65535));
		end
		return k;
	endfunction

	// rewrite one entry; inside the used range keep the order where it holds
	task automatic touch_entry(input int n);
		int i;
		int lo;
		int hi;
		if (n < CAPACITY && (n == 0 || $urandom_range(1) == 1)) begin
			i = $urandom_range(CAPACITY - 1, n);
			send_beat(OP_WRITE, i, key_t'($urandom_range(65535)));
			if (i < sorted_len) begin
				sorted_len = i;
			end
		end else begin
			i  = $urandom_range(n - 1);
			lo = (i == 0 || i >= sorted_len) ? 0 : int'(shadow[i - 1]);
			hi = (i + 1 >= sorted_len) ? 65535 : int'(shadow[i + 1]);
			if (lo > hi) begin
				lo = 0;
				hi = 65535;
			end
			send_beat(OP_WRITE, i, key_t'($urandom_range(hi, lo)));
		end
	endtask

	task automatic run_mix(input int n, input int m);
		for (int j = 0; j < m; j++) begin
			if ($urandom_range(3) == 0) begin
				touch_entry(n);
			end else begin
				send_beat(OP_QUERY, $urandom_range(CAPACITY - 1), pick_query_key(n));
			end
		end
	endtask

	initial begin
		int goal;
		int phase;
		int r;
		int n;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		set_count(0);
		send_beat(OP_QUERY, 0, 16'h0000);
		send_beat(OP_QUERY, CAPACITY - 1, 16'hFFFF);
		send_beat(OP_WRITE, 0, 16'd0);
		send_beat(OP_WRITE, 1, 16'd3);
		send_beat(OP_WRITE, 2, 16'd3);
		send_beat(OP_WRITE, 3, 16'd9);
		send_beat(OP_WRITE, 4, 16'd200);
		send_beat(OP_WRITE, 5, 16'hFFFF);
		set_count(6);
		send_beat(OP_QUERY, 0, 16'd0);
		send_beat(OP_QUERY, 0, 16'd3);
		send_beat(OP_QUERY, 0, 16'd4);
		send_beat(OP_QUERY, 0, 16'd9);
		send_beat(OP_QUERY, 0, 16'hFFFF);
		send_beat(OP_QUERY, 0, 16'hFFFE);
		send_beat(OP_WRITE, 0, 16'd500);
		send_beat(OP_QUERY, 0, 16'd3);
		send_beat(OP_QUERY, 0, 16'd500);
		send_beat(OP_WRITE, CAPACITY - 1, 16'hFFFF);

		sorted_len = 0;

		goal  = RANDOM_ITEMS;
		phase = 0;
		while (beats < goal) begin
			idle_pct = idle_plan[phase % 4];
			phase++;
			r = $urandom_range(99);
			if (r < 10) begin
				n = $urandom_range(7);
			end else if (r < 25) begin
				n = $urandom_range(31, 8);
			end else if (r < 80) begin
				n = $urandom_range(200, 32);
			end else if (r < 95) begin
				n = $urandom_range(400, 201);
			end else begin
				n = $urandom_range(520, 401);
			end
			if (n <= 64 && $urandom_range(9) == 0) begin
				load_unsorted(n);
			end else if (n > sorted_len) begin
				load_sorted(sorted_len, n);
			end else if (n <= 256 && $urandom_range(1) == 1) begin
				load_sorted(0, n);
			end
			set_count(n);
			run_mix(n, $urandom_range(60, 20));
		end

		wait_idle();
		if (mismatch_count == 0 && found_owed == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
